>>> design/slfr_pkg.sv
package slfr_pkg;

  typedef enum logic {
    OP_RECEIVE = 1'b0,
    OP_READ    = 1'b1
  } opcode_e;

  typedef struct packed {
    logic       is_read;
    logic       frame_done;
    logic       length_error;
    logic       out_of_range;
    logic [7:0] payload_length;
  } result_t;

  localparam int unsigned MinLengthByte = 2;

endpackage

>>> design/slfr_ram.sv
module slfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/start_length_frame_receiver.sv
// start/length framed byte receiver with payload read port
//
// input channel (in_valid_i / in_ready_o): one transaction per item; opcode_i
// selects between taking rx_byte_i into the framer and reading the payload
// byte at read_index_i. a frame is the start byte (cfg_wdata_i, written with
// cfg_we_i), a length byte L, then L-1 payload bytes kept in a payload ram.
// lengths 0, 1 and any with L-1 at or beyond BUFFER_DEPTH are dropped with
// length_error_o.
// output channel (out_valid_o / out_ready_i): exactly one result transaction
// per item, in order, always carrying the payload length after that item.
// out_valid_o rises in the cycle after acceptance; throughput is one item per cycle
// while the receiver does not stall, set by the single-port-per-direction payload
// ram whose registered read feeds read_data_o directly.
// when the receiver stalls the result is held and a new item is taken only in
// the cycle the held result leaves; the ram read register is not reloaded
// meanwhile.
// reset clears the framer to hunting, the length to 0, the start byte to 0 and
// the output valid; the payload ram is not cleared.
module start_length_frame_receiver #(
  parameter int unsigned BUFFER_DEPTH = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       frame_done_o,
  output logic       length_error_o,
  output logic [7:0] read_data_o,
  output logic       read_out_of_range_o,
  output logic [7:0] payload_length_o
);
  import slfr_pkg::*;

  localparam int unsigned AddrW = $clog2(BUFFER_DEPTH);
  localparam logic [7:0] DepthByte = 8'(BUFFER_DEPTH);
  localparam logic [7:0] MinLen = 8'(MinLengthByte);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [AddrW-1:0] write_pos_q, write_pos_d;
  logic [7:0]       frame_len_q, frame_len_d;
  logic [7:0]       start_marker_q;
  logic             out_valid_q;
  result_t          res_q, res_d;

  logic             accept;
  logic             ram_we;
  logic             ram_re;
  logic [AddrW-1:0] wp_inc;
  logic [7:0]       ram_rdata;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign wp_inc     = write_pos_q + AddrW'(1);

  always_comb begin
    phase_d     = phase_q;
    write_pos_d = write_pos_q;
    frame_len_d = frame_len_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    res_d       = '0;
    if (opcode_e'(opcode_i) == OP_READ) begin
      res_d.is_read      = 1'b1;
      res_d.out_of_range = !(read_index_i < frame_len_q);
      ram_re             = accept && (read_index_i < frame_len_q);
    end else begin
      case (phase_q)
        PH_LEN: begin
          if ((rx_byte_i < MinLen) || (rx_byte_i > DepthByte)) begin
            res_d.length_error = 1'b1;
            frame_len_d        = '0;
            phase_d            = PH_HUNT;
          end else begin
            frame_len_d = rx_byte_i - 8'd1;
            write_pos_d = '0;
            phase_d     = PH_DATA;
          end
        end
        PH_DATA: begin
          ram_we      = accept;
          write_pos_d = wp_inc;
          if (8'(wp_inc) >= frame_len_q) begin
            res_d.frame_done = 1'b1;
            phase_d          = PH_HUNT;
          end
        end
        default: begin
          phase_d = (rx_byte_i == start_marker_q) ? PH_LEN : PH_HUNT;
        end
      endcase
    end
    res_d.payload_length = frame_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HUNT;
      write_pos_q    <= '0;
      frame_len_q    <= '0;
      start_marker_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        start_marker_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q     <= phase_d;
        write_pos_q <= write_pos_d;
        frame_len_q <= frame_len_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  slfr_ram #(
    .Width(8),
    .Depth(BUFFER_DEPTH)
  ) u_payload_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(write_pos_q),
    .wdata_i(rx_byte_i),
    .re_i   (ram_re),
    .raddr_i(read_index_i[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o         = out_valid_q;
  assign frame_done_o        = res_q.frame_done;
  assign length_error_o      = res_q.length_error;
  assign read_out_of_range_o = res_q.out_of_range;
  assign payload_length_o    = res_q.payload_length;
  assign read_data_o         = (res_q.is_read && !res_q.out_of_range) ? ram_rdata : 8'd0;

`ifndef SYNTH
  a_err_clears_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_error_o |-> payload_length_o == 8'd0)
    else $error("length error with nonzero payload length");

  a_done_not_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_done_o && length_error_o))
    else $error("frame done and length error together");

  a_done_has_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> payload_length_o != 8'd0)
    else $error("frame done with empty payload");

  a_data_len_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> (frame_len_q != 8'd0) && (frame_len_q < DepthByte)
      && (8'(write_pos_q) < frame_len_q))
    else $error("payload write position outside frame");
`endif

endmodule

>>> dv/start_length_frame_receiver_test.sv
`timescale 1ns / 100ps

module start_length_frame_receiver_test;
  import slfr_pkg::*;

  localparam int unsigned Depth         = 20;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 112;
  localparam int unsigned QuietLimit    = 4000;

  typedef enum logic [1:0] {
    HUNTING,
    AWAIT_LENGTH,
    IN_PAYLOAD
  } rx_phase_e;

  typedef struct packed {
    opcode_e    op;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } request_t;

  typedef struct packed {
    logic       frame_done;
    logic       length_error;
    logic [7:0] read_data;
    logic       out_of_range;
    logic [7:0] payload_length;
  } response_t;

  class frame_scoreboard;
    logic [7:0]  start_marker;
    rx_phase_e   phase;
    logic [7:0]  payload_mem [Depth];
    bit          filled [Depth];
    int unsigned write_pos;
    logic [7:0]  frame_len;
    response_t   pending_q [$];
    int unsigned errors;
    int unsigned frames;
    int unsigned length_errors;
    int unsigned good_reads;
    int unsigned bad_reads;

    function new();
      start_marker  = 8'h00;
      phase         = HUNTING;
      write_pos     = 0;
      frame_len     = 8'd0;
      errors        = 0;
      frames        = 0;
      length_errors = 0;
      good_reads    = 0;
      bad_reads     = 0;
      foreach (filled[i]) filled[i] = 1'b0;
    endfunction

    // advance the frame state for one accepted transaction
    function void note_input(request_t req);
      response_t rsp;
      rsp = '0;
      if (req.op == OP_READ) begin
        if (req.read_index < frame_len && req.read_index < Depth) begin
          rsp.read_data = payload_mem[req.read_index];
          good_reads++;
        end else begin
          rsp.out_of_range = 1'b1;
          bad_reads++;
        end
      end else begin
        case (phase)
          AWAIT_LENGTH: begin
            if (req.rx_byte < MinLengthByte || int'(req.rx_byte) - 1 >= int'(Depth)) begin
              rsp.length_error = 1'b1;
              frame_len        = 8'd0;
              phase            = HUNTING;
              length_errors++;
            end else begin
              frame_len = req.rx_byte - 8'd1;
              write_pos = 0;
              phase     = IN_PAYLOAD;
            end
          end
          IN_PAYLOAD: begin
            if (write_pos < Depth) begin
              payload_mem[write_pos] = req.rx_byte;
              filled[write_pos]      = 1'b1;
            end
            write_pos++;
            if (write_pos >= frame_len) begin
              rsp.frame_done = 1'b1;
              phase          = HUNTING;
              frames++;
            end
          end
          default: phase = (req.rx_byte == start_marker) ? AWAIT_LENGTH : HUNTING;
        endcase
      end
      rsp.payload_length = frame_len;
      pending_q.push_back(rsp);
    endfunction

    function void check_result(response_t got);
      response_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction %h", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done: expected %0d, actual %0d", want.frame_done, got.frame_done);
        errors++;
      end
      if (got.length_error !== want.length_error) begin
        $error("length_error: expected %0d, actual %0d", want.length_error, got.length_error);
        errors++;
      end
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
        errors++;
      end
      if (got.out_of_range !== want.out_of_range) begin
        $error("read_out_of_range: expected %0d, actual %0d", want.out_of_range,
               got.out_of_range);
        errors++;
      end
      if (got.payload_length !== want.payload_length) begin
        $error("payload_length: expected %0d, actual %0d", want.payload_length,
               got.payload_length);
        errors++;
      end
    endfunction

    // mostly in range, some at the end, some anywhere; never an unwritten entry
    function logic [7:0] pick_read_index();
      int unsigned r;
      logic [7:0]  idx;
      r = $urandom_range(99);
      if (frame_len != 0 && r < 60) idx = 8'($urandom_range(frame_len - 1));
      else if (r < 80) idx = 8'(frame_len + $urandom_range(1));
      else idx = 8'($urandom_range(255));
      if (idx < frame_len && idx < Depth && !filled[idx]) idx = frame_len;
      return idx;
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       opcode_i = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic [7:0] read_index_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       frame_done_o;
  logic       length_error_o;
  logic [7:0] read_data_o;
  logic       read_out_of_range_o;
  logic [7:0] payload_length_o;

  frame_scoreboard sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     accepted = 0;
  int unsigned     configs = 0;
  int unsigned     quiet_cycles = 0;

  start_length_frame_receiver #(
    .BUFFER_DEPTH(Depth)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .rx_byte_i          (rx_byte_i),
    .read_index_i       (read_index_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .frame_done_o       (frame_done_o),
    .length_error_o     (length_error_o),
    .read_data_o        (read_data_o),
    .read_out_of_range_o(read_out_of_range_o),
    .payload_length_o   (payload_length_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : result_monitor
    response_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.frame_done     = frame_done_o;
      seen.length_error   = length_error_o;
      seen.read_data      = read_data_o;
      seen.out_of_range   = read_out_of_range_o;
      seen.payload_length = payload_length_o;
      sb.check_result(seen);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("FAIL start_length_frame_receiver");
      $finish;
    end
  end

  task automatic drive_request(request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= req.op;
    rx_byte_i    <= req.rx_byte;
    read_index_i <= req.read_index;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(req);
    accepted++;
  endtask

  task automatic send_rx(logic [7:0] b);
    request_t req;
    req.op         = OP_RECEIVE;
    req.rx_byte    = b;
    req.read_index = 8'($urandom_range(255));
    drive_request(req);
  endtask

  task automatic send_read(logic [7:0] idx);
    request_t req;
    req.op         = OP_READ;
    req.rx_byte    = 8'($urandom_range(255));
    req.read_index = idx;
    drive_request(req);
  endtask

  task automatic write_marker(logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.start_marker = value;
    configs++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // start byte, length byte, then some payload with reads mixed in
  task automatic send_frame(logic [7:0] len, int unsigned n_payload);
    send_rx(sb.start_marker);
    send_rx(len);
    repeat (n_payload) begin
      if ($urandom_range(99) < 15) send_read(sb.pick_read_index());
      send_rx(8'($urandom_range(255)));
    end
  endtask

  task automatic random_burst();
    int unsigned r;
    int unsigned s;
    logic [7:0]  len;
    r = $urandom_range(99);
    s = $urandom_range(9);
    if (r < 65) begin
      if (s < 2) len = 8'(Depth);
      else if (s < 3) len = 8'(Depth - 1);
      else len = 8'($urandom_range(8, 2));
      send_frame(len, 32'(len) - 1);
      if ($urandom_range(1)) repeat ($urandom_range(3, 1)) send_read(sb.pick_read_index());
    end else if (r < 75) begin
      if (s < 3) len = 8'd0;
      else if (s < 6) len = 8'd1;
      else if (s < 8) len = 8'(Depth + 1);
      else len = 8'($urandom_range(255, Depth + 1));
      send_frame(len, 0);
    end else if (r < 85) begin
      // cut short, so the next bytes land in this payload
      len = 8'($urandom_range(Depth, 3));
      send_frame(len, $urandom_range(32'(len) - 2, 1));
    end else begin
      repeat ($urandom_range(4, 1)) begin
        if ($urandom_range(1)) send_read(sb.pick_read_index());
        else send_rx(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    logic [7:0]  marker_val;
    int unsigned target;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_marker(8'hC3);
    send_read(8'd0);
    send_rx(8'h00);
    send_rx(8'hC3);
    send_rx(8'd0);
    send_rx(8'hC3);
    send_rx(8'd1);
    send_rx(8'hC3);
    send_rx(8'(Depth + 1));
    send_rx(8'hC3);
    send_rx(8'd255);
    send_rx(8'hC3);
    send_rx(8'd2);
    send_rx(8'hFF);
    send_read(8'd0);
    send_read(8'd1);
    send_read(8'd255);
    // read while a new frame is arriving returns the old byte
    send_rx(8'hC3);
    send_rx(8'd3);
    send_read(8'd0);
    send_rx(8'h00);
    send_rx(8'h5A);
    send_read(8'd1);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 86;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 86;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      if (p == 0) marker_val = 8'h00;
      else if (p == 1) marker_val = 8'hFF;
      else marker_val = 8'($urandom_range(255));
      write_marker(marker_val);
      target = accepted + ItemsPerPhase;
      while (accepted < target) random_burst();
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("run covered %0d items over %0d start byte settings and four idling patterns",
             accepted, configs);
    $display("%0d frames completed, %0d length errors, %0d reads in range, %0d out of range",
             sb.frames, sb.length_errors, sb.good_reads, sb.bad_reads);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS start_length_frame_receiver");
    end else begin
      $display("FAIL start_length_frame_receiver");
    end
    $finish;
  end

endmodule
